// File: design/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// Shared widths, phase codes and command codes of the stall homing sequencer.
// ----------------------------------------------------------------------------
package shs_pkg;

  localparam int unsigned SvW    = 10;
  localparam int unsigned PosW   = 31;
  localparam int unsigned RangeW = 32;
  localparam int unsigned TickW  = 16;
  localparam int unsigned CmdW   = 3;
  localparam int unsigned PhaseW = 3;

  localparam logic [PhaseW-1:0] PhIdle     = 3'd0;
  localparam logic [PhaseW-1:0] PhSeekLow  = 3'd1;
  localparam logic [PhaseW-1:0] PhCapLow   = 3'd2;
  localparam logic [PhaseW-1:0] PhBackoff  = 3'd3;
  localparam logic [PhaseW-1:0] PhSeekHigh = 3'd4;
  localparam logic [PhaseW-1:0] PhCapHigh  = 3'd5;
  localparam logic [PhaseW-1:0] PhCenter   = 3'd6;

  localparam logic [CmdW-1:0] CmdNone     = 3'd0;
  localparam logic [CmdW-1:0] CmdRunBack  = 3'd1;
  localparam logic [CmdW-1:0] CmdStop     = 3'd2;
  localparam logic [CmdW-1:0] CmdMoveRel  = 3'd3;
  localparam logic [CmdW-1:0] CmdRunFwd   = 3'd4;
  localparam logic [CmdW-1:0] CmdMoveTo   = 3'd5;
  localparam logic [CmdW-1:0] CmdZeroRest = 3'd6;

  localparam logic OpTick  = 1'b0;
  localparam logic OpStart = 1'b1;

  localparam logic [1:0] RegThreshold = 2'd0;
  localparam logic [1:0] RegTimeout   = 2'd1;
  localparam logic [1:0] RegBlank     = 2'd2;
  localparam logic [1:0] RegBackoff   = 2'd3;

endpackage

// File: design/shs_in_if.sv
// ----------------------------------------------------------------------------
// shs_in_if
// Input item channel: start or tick with load reading, position, run flag.
// ----------------------------------------------------------------------------
interface shs_in_if
  import shs_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic                   op;
  logic [SvW-1:0]         stall_value;
  logic signed [PosW-1:0] position;
  logic                   motor_running;

  modport source (
    output valid, op, stall_value, position, motor_running,
    input  ready
  );
  modport sink (
    input  valid, op, stall_value, position, motor_running,
    output ready
  );
endinterface

// File: design/shs_out_if.sv
// ----------------------------------------------------------------------------
// shs_out_if
// Result item channel: motor command, phase and recorded homing results.
// ----------------------------------------------------------------------------
interface shs_out_if
  import shs_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [CmdW-1:0]          command;
  logic signed [PosW-1:0]   command_value;
  logic [PhaseW-1:0]        phase;
  logic                     low_stalled;
  logic                     high_stalled;
  logic signed [PosW-1:0]   low_position;
  logic signed [PosW-1:0]   high_position;
  logic signed [RangeW-1:0] travel_range;
  logic                     done_res;

  modport source (
    output valid, command, command_value, phase, low_stalled, high_stalled,
           low_position, high_position, travel_range, done_res,
    input  ready
  );
  modport sink (
    input  valid, command, command_value, phase, low_stalled, high_stalled,
           low_position, high_position, travel_range, done_res,
    output ready
  );
endinterface

// File: design/stall_homing_sequencer.sv
// Pipeline: two register stages (input, result); an accepted item waits in the input register
// until the result register is free or being taken, then its result is registered and offered.
// Throughput: one item per cycle while results are taken; the input register refills while the
// result is taken. The sequencer state is updated together with the result register.
// Reset: asynchronous, active low; phase idle, counters, positions and flags cleared,
// configuration registers back to 100 / 10000 / 500 / 200.
// ----------------------------------------------------------------------------
// stall_homing_sequencer
// Sensorless stall homing for one stepper axis: seeks both end stops, then
// centers the axis and zeroes the position.
// ----------------------------------------------------------------------------
module stall_homing_sequencer
  import shs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  shs_in_if.sink      in_ch,
  shs_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration
  logic [SvW-1:0]   thr_q;
  logic [TickW-1:0] timeout_q;
  logic [TickW-1:0] blank_q;
  logic [TickW-1:0] backoff_q;
  logic             cfg_wr;
  logic [1:0]       cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= 10'd100;
      timeout_q <= 16'd10000;
      blank_q   <= 16'd500;
      backoff_q <= 16'd200;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegThreshold: thr_q     <= pwdata[SvW-1:0];
        RegTimeout:   timeout_q <= pwdata[TickW-1:0];
        RegBlank:     blank_q   <= pwdata[TickW-1:0];
        RegBackoff:   backoff_q <= pwdata[TickW-1:0];
        default:      thr_q     <= thr_q;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegThreshold: prdata = {22'd0, thr_q};
      RegTimeout:   prdata = {16'd0, timeout_q};
      RegBlank:     prdata = {16'd0, blank_q};
      RegBackoff:   prdata = {16'd0, backoff_q};
      default:      prdata = 32'd0;
    endcase
  end

  // input register
  logic                   in_valid_q;
  logic                   in_op_q;
  logic [SvW-1:0]         in_sv_q;
  logic signed [PosW-1:0] in_pos_q;
  logic                   in_run_q;
  logic                   out_valid_q;
  logic                   advance;
  logic                   in_take;

  assign advance     = in_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready = !in_valid_q || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_op_q  <= in_ch.op;
      in_sv_q  <= in_ch.stall_value;
      in_pos_q <= in_ch.position;
      in_run_q <= in_ch.motor_running;
    end
  end

  // sequencer state
  logic [PhaseW-1:0]      phase_q, phase_d;
  logic [TickW-1:0]       elapsed_q, elapsed_d;
  logic signed [PosW-1:0] low_pos_q, low_pos_d;
  logic signed [PosW-1:0] high_pos_q, high_pos_d;
  logic                   low_stall_q, low_stall_d;
  logic                   high_stall_q, high_stall_d;

  logic [TickW-1:0]         elapsed_inc;
  logic                     seek_timeout;
  logic                     seek_stall;
  logic signed [RangeW-1:0] pos_sum;
  logic signed [RangeW-1:0] sum_adj;
  logic [CmdW-1:0]          cmd;
  logic signed [PosW-1:0]   cval;
  logic                     done;

  assign elapsed_inc  = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
  assign seek_timeout = elapsed_inc >= timeout_q;
  assign seek_stall   = (elapsed_inc > blank_q) && (in_sv_q < thr_q);
  assign pos_sum      = {low_pos_q[PosW-1], low_pos_q} + {in_pos_q[PosW-1], in_pos_q};
  assign sum_adj      = pos_sum + {{(RangeW-1){1'b0}}, pos_sum[RangeW-1]};

  always_comb begin
    phase_d      = phase_q;
    elapsed_d    = elapsed_q;
    low_pos_d    = low_pos_q;
    high_pos_d   = high_pos_q;
    low_stall_d  = low_stall_q;
    high_stall_d = high_stall_q;
    cmd          = CmdNone;
    cval         = '0;
    done         = 1'b0;
    if (in_op_q == OpStart) begin
      if (phase_q == PhIdle) begin
        low_stall_d  = 1'b0;
        high_stall_d = 1'b0;
        elapsed_d    = '0;
        phase_d      = PhSeekLow;
        cmd          = CmdRunBack;
      end
    end else begin
      unique case (phase_q)
        PhIdle: begin
          phase_d = PhIdle;
        end
        PhSeekLow: begin
          elapsed_d = elapsed_inc;
          if (seek_timeout || seek_stall) begin
            low_stall_d = !seek_timeout;
            cmd         = seek_timeout ? CmdNone : CmdStop;
            phase_d     = PhCapLow;
          end
        end
        PhCapLow: begin
          low_pos_d = in_pos_q;
          cmd       = CmdMoveRel;
          cval      = PosW'(backoff_q);
          phase_d   = PhBackoff;
        end
        PhBackoff: begin
          if (!in_run_q) begin
            elapsed_d = '0;
            cmd       = CmdRunFwd;
            phase_d   = PhSeekHigh;
          end
        end
        PhSeekHigh: begin
          elapsed_d = elapsed_inc;
          if (seek_timeout || seek_stall) begin
            high_stall_d = !seek_timeout;
            cmd          = seek_timeout ? CmdNone : CmdStop;
            phase_d      = PhCapHigh;
          end
        end
        PhCapHigh: begin
          high_pos_d = in_pos_q;
          cmd        = CmdMoveTo;
          cval       = sum_adj[RangeW-1:1];
          phase_d    = PhCenter;
        end
        PhCenter: begin
          if (!in_run_q) begin
            cmd     = CmdZeroRest;
            done    = 1'b1;
            phase_d = PhIdle;
          end
        end
        default: begin
          phase_d = PhIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      elapsed_q    <= '0;
      low_pos_q    <= '0;
      high_pos_q   <= '0;
      low_stall_q  <= 1'b0;
      high_stall_q <= 1'b0;
    end else if (advance) begin
      phase_q      <= phase_d;
      elapsed_q    <= elapsed_d;
      low_pos_q    <= low_pos_d;
      high_pos_q   <= high_pos_d;
      low_stall_q  <= low_stall_d;
      high_stall_q <= high_stall_d;
    end
  end

  // result register
  logic [CmdW-1:0]          res_cmd_q;
  logic signed [PosW-1:0]   res_cval_q;
  logic [PhaseW-1:0]        res_phase_q;
  logic                     res_lstall_q;
  logic                     res_hstall_q;
  logic signed [PosW-1:0]   res_lpos_q;
  logic signed [PosW-1:0]   res_hpos_q;
  logic signed [RangeW-1:0] res_range_q;
  logic                     res_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_cmd_q    <= cmd;
      res_cval_q   <= cval;
      res_phase_q  <= phase_d;
      res_lstall_q <= low_stall_d;
      res_hstall_q <= high_stall_d;
      res_lpos_q   <= low_pos_d;
      res_hpos_q   <= high_pos_d;
      res_range_q  <= {high_pos_d[PosW-1], high_pos_d} - {low_pos_d[PosW-1], low_pos_d};
      res_done_q   <= done;
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.command       = res_cmd_q;
  assign out_ch.command_value = res_cval_q;
  assign out_ch.phase         = res_phase_q;
  assign out_ch.low_stalled   = res_lstall_q;
  assign out_ch.high_stalled  = res_hstall_q;
  assign out_ch.low_position  = res_lpos_q;
  assign out_ch.high_position = res_hpos_q;
  assign out_ch.travel_range  = res_range_q;
  assign out_ch.done_res      = res_done_q;

  a_stall_only_on_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ch.ready |-> (in_valid_q && out_valid_q && !out_ch.ready))
    else $error("input stalled without a blocked result");

  a_advance_fills_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result register empty after an advance");

  a_done_goes_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_done_q) |-> (res_cmd_q == CmdZeroRest && res_phase_q == PhIdle))
    else $error("done result without zero command or idle phase");

  a_phase_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 3'd7)
    else $error("phase register holds an unused code");

  a_elapsed_steps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(elapsed_q))
    else $error("tick counter changed without an item");

endmodule

// File: tb/sv/stall_homing_sequencer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stall_homing_sequencer_tb
// Self-checking bench for the stall homing sequencer. Directed runs cover
// both stall and timeout ends, the extremes of every field and register, the
// ignored starts and ticks, and center truncation. Random well-formed homing
// runs follow, under changing register settings. An in-bench model predicts
// every result, and a monitor compares each result field by field. Both
// channels idle at random, the result side holds off long enough to fill the
// block, and the register port is written and read back between runs.
// ----------------------------------------------------------------------------
module stall_homing_sequencer_tb;
  import shs_pkg::*;

  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned RandomItems   = 1200;

  localparam logic [1:0] SeekGoing    = 2'd0;
  localparam logic [1:0] SeekStalled  = 2'd1;
  localparam logic [1:0] SeekTimedOut = 2'd2;

  typedef struct {
    logic                   op;
    logic [SvW-1:0]         stall_value;
    logic signed [PosW-1:0] position;
    logic                   motor_running;
  } homing_item_t;

  typedef struct {
    logic [CmdW-1:0]          command;
    logic signed [PosW-1:0]   command_value;
    logic [PhaseW-1:0]        phase;
    logic                     low_stalled;
    logic                     high_stalled;
    logic signed [PosW-1:0]   low_position;
    logic signed [PosW-1:0]   high_position;
    logic signed [RangeW-1:0] travel_range;
    logic                     done_res;
  } homing_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  shs_in_if  in_ch ();
  shs_out_if out_ch ();

  stall_homing_sequencer u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [SvW-1:0]         cfg_threshold = 10'd100;
  logic [TickW-1:0]       cfg_timeout   = 16'd10000;
  logic [TickW-1:0]       cfg_blank     = 16'd500;
  logic [TickW-1:0]       cfg_backoff   = 16'd200;

  logic [PhaseW-1:0]      seq_phase   = PhIdle;
  logic [TickW-1:0]       seq_elapsed = '0;
  logic signed [PosW-1:0] low_pos     = '0;
  logic signed [PosW-1:0] high_pos    = '0;
  logic                   low_flag    = 1'b0;
  logic                   high_flag   = 1'b0;

  homing_result_t pending_results[$];
  homing_result_t want_r;

  bit          idling_on       = 1'b1;
  bit          rx_hold_pending = 1'b0;
  int unsigned fail_count      = 0;
  int unsigned cycle_count     = 0;
  int unsigned sent_items      = 0;
  int unsigned checked_results = 0;
  int unsigned homing_runs     = 0;
  int unsigned stall_ends      = 0;
  int unsigned timeout_ends    = 0;
  int unsigned config_writes   = 0;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [1:0] seek_tick(logic [SvW-1:0] sv);
    if (seq_elapsed != '1) seq_elapsed++;
    if (seq_elapsed >= cfg_timeout) return SeekTimedOut;
    if (seq_elapsed > cfg_blank && sv < cfg_threshold) return SeekStalled;
    return SeekGoing;
  endfunction

  function automatic homing_result_t homing_step(homing_item_t it);
    homing_result_t r;
    logic [1:0]     outcome;
    int             sum;
    r.command       = CmdNone;
    r.command_value = '0;
    r.done_res      = 1'b0;
    if (it.op == OpStart) begin
      if (seq_phase == PhIdle) begin
        low_flag    = 1'b0;
        high_flag   = 1'b0;
        seq_elapsed = '0;
        seq_phase   = PhSeekLow;
        r.command   = CmdRunBack;
      end
    end else begin
      case (seq_phase)
        PhSeekLow, PhSeekHigh: begin
          outcome = seek_tick(it.stall_value);
          if (outcome != SeekGoing) begin
            if (outcome == SeekStalled) stall_ends++;
            else timeout_ends++;
            r.command = (outcome == SeekStalled) ? CmdStop : CmdNone;
            if (seq_phase == PhSeekLow) begin
              low_flag  = (outcome == SeekStalled);
              seq_phase = PhCapLow;
            end else begin
              high_flag = (outcome == SeekStalled);
              seq_phase = PhCapHigh;
            end
          end
        end
        PhCapLow: begin
          low_pos         = it.position;
          r.command       = CmdMoveRel;
          r.command_value = {{(PosW-TickW){1'b0}}, cfg_backoff};
          seq_phase       = PhBackoff;
        end
        PhBackoff: begin
          if (!it.motor_running) begin
            seq_elapsed = '0;
            r.command   = CmdRunFwd;
            seq_phase   = PhSeekHigh;
          end
        end
        PhCapHigh: begin
          high_pos        = it.position;
          sum             = int'(low_pos) + int'(high_pos);
          r.command       = CmdMoveTo;
          r.command_value = PosW'(sum / 2);
          seq_phase       = PhCenter;
        end
        PhCenter: begin
          if (!it.motor_running) begin
            r.command  = CmdZeroRest;
            r.done_res = 1'b1;
            seq_phase  = PhIdle;
            homing_runs++;
          end
        end
        default: seq_phase = PhIdle;
      endcase
    end
    r.phase         = seq_phase;
    r.low_stalled   = low_flag;
    r.high_stalled  = high_flag;
    r.low_position  = low_pos;
    r.high_position = high_pos;
    r.travel_range  = int'(high_pos) - int'(low_pos);
    return r;
  endfunction

  function automatic void check_field(string name, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual command %0d",
                 $time, out_ch.command);
        fail_count++;
      end else begin
        want_r = pending_results.pop_front();
        check_field("command", want_r.command, out_ch.command);
        check_field("command_value", want_r.command_value, out_ch.command_value);
        check_field("phase", want_r.phase, out_ch.phase);
        check_field("low_stalled", want_r.low_stalled, out_ch.low_stalled);
        check_field("high_stalled", want_r.high_stalled, out_ch.high_stalled);
        check_field("low_position", want_r.low_position, out_ch.low_position);
        check_field("high_position", want_r.high_position, out_ch.high_position);
        check_field("travel_range", want_r.travel_range, out_ch.travel_range);
        check_field("done_res", want_r.done_res, out_ch.done_res);
        checked_results++;
      end
    end
  end

  initial begin
    int unsigned rx_wait;
    rx_wait = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_pending) begin
        rx_hold_pending = 1'b0;
        rx_wait         = HoldOffCycles;
      end
      if (rx_wait > 0) begin
        out_ch.ready <= 1'b0;
        rx_wait--;
      end else if (idling_on && $urandom_range(0, 99) < 25) begin
        out_ch.ready <= 1'b0;
        rx_wait = pick_gap() - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(homing_item_t it);
    int unsigned gap;
    gap = 0;
    if (idling_on && $urandom_range(0, 99) < 40) gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.op            <= it.op;
    in_ch.stall_value   <= it.stall_value;
    in_ch.position      <= it.position;
    in_ch.motor_running <= it.motor_running;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_results.push_back(homing_step(it));
    sent_items++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic apb_access(logic wr, logic [1:0] idx, logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_reg(logic [1:0] idx, logic [31:0] want);
    logic [31:0] rdata;
    apb_access(1'b0, idx, '0, rdata);
    check_field("register readback", want, rdata);
  endtask

  task automatic program_reg(logic [1:0] idx, logic [31:0] value);
    logic [31:0] rdata;
    apb_access(1'b1, idx, value, rdata);
    case (idx)
      RegThreshold: cfg_threshold = value[SvW-1:0];
      RegTimeout:   cfg_timeout   = value[TickW-1:0];
      RegBlank:     cfg_blank     = value[TickW-1:0];
      default:      cfg_backoff   = value[TickW-1:0];
    endcase
    config_writes++;
    check_reg(idx, value);
  endtask

  function automatic homing_item_t make_item(logic op, int unsigned sv, int pos,
                                             logic run);
    homing_item_t it;
    it.op            = op;
    it.stall_value   = sv[SvW-1:0];
    it.position      = pos[PosW-1:0];
    it.motor_running = run;
    return it;
  endfunction

  function automatic homing_item_t next_item();
    homing_item_t it;
    it.op            = OpTick;
    it.stall_value   = SvW'($urandom);
    it.position      = PosW'($urandom);
    it.motor_running = 1'($urandom);
    case ($urandom_range(0, 19))
      0: it.position = {1'b0, {(PosW-1){1'b1}}};
      1: it.position = {1'b1, {(PosW-1){1'b0}}};
      2: it.stall_value = '0;
      3: it.stall_value = '1;
      default: ;
    endcase
    case (seq_phase)
      PhIdle: if ($urandom_range(0, 99) < 85) it.op = OpStart;
      PhSeekLow, PhSeekHigh: begin
        if ($urandom_range(0, 99) < 4) it.op = OpStart;
        else if ($urandom_range(0, 99) < 25 && cfg_threshold != 0)
          it.stall_value = SvW'($urandom_range(0, cfg_threshold - 1));
      end
      PhBackoff, PhCenter: it.motor_running = ($urandom_range(0, 99) < 55);
      default: ;
    endcase
    return it;
  endfunction

  task automatic random_config();
    int unsigned thr;
    int unsigned tmo;
    int unsigned blk;
    int unsigned bko;
    case ($urandom_range(0, 9))
      0: thr = 0;
      1: thr = 1023;
      default: thr = $urandom_range(0, 1023);
    endcase
    case ($urandom_range(0, 9))
      0: tmo = 0;
      1: tmo = 1;
      2: tmo = 65535;
      default: tmo = $urandom_range(2, 60);
    endcase
    if (tmo == 65535) begin
      blk = $urandom_range(0, 20);
      if (thr < 200) thr = $urandom_range(200, 1023);
    end else begin
      case ($urandom_range(0, 9))
        0: blk = 0;
        1: blk = 65535;
        default: blk = $urandom_range(0, tmo + 5);
      endcase
    end
    case ($urandom_range(0, 9))
      0: bko = 0;
      1: bko = 65535;
      default: bko = $urandom_range(0, 65535);
    endcase
    program_reg(RegThreshold, thr);
    program_reg(RegTimeout, tmo);
    program_reg(RegBlank, blk);
    program_reg(RegBackoff, bko);
  endtask

  task automatic test_reset_values();
    check_reg(RegThreshold, 32'd100);
    check_reg(RegTimeout, 32'd10000);
    check_reg(RegBlank, 32'd500);
    check_reg(RegBackoff, 32'd200);
  endtask

  task automatic test_stall_low_timeout_high();
    program_reg(RegThreshold, 1023);
    program_reg(RegTimeout, 4);
    program_reg(RegBlank, 2);
    program_reg(RegBackoff, 0);
    send_item(make_item(OpTick, 1023, 1073741823, 1'b1));
    send_item(make_item(OpStart, 0, -1073741824, 1'b0));
    send_item(make_item(OpStart, 0, 0, 1'b1));
    send_item(make_item(OpTick, 0, 5, 1'b1));
    send_item(make_item(OpTick, 0, 6, 1'b0));
    send_item(make_item(OpTick, 1022, 7, 1'b1));
    send_item(make_item(OpTick, 512, 1073741823, 1'b1));
    send_item(make_item(OpTick, 0, 0, 1'b1));
    send_item(make_item(OpTick, 0, 0, 1'b0));
    repeat (4) send_item(make_item(OpTick, 1023, 0, 1'b1));
    send_item(make_item(OpTick, 0, -1073741824, 1'b0));
    send_item(make_item(OpTick, 0, 0, 1'b1));
    send_item(make_item(OpStart, 0, 0, 1'b0));
    send_item(make_item(OpTick, 0, 0, 1'b0));
    drain_results();
  endtask

  task automatic test_zero_timeout();
    program_reg(RegThreshold, 0);
    program_reg(RegTimeout, 0);
    program_reg(RegBlank, 65535);
    program_reg(RegBackoff, 65535);
    send_item(make_item(OpStart, 100, 0, 1'b0));
    send_item(make_item(OpTick, 0, 0, 1'b0));
    send_item(make_item(OpTick, 0, -3, 1'b1));
    send_item(make_item(OpTick, 0, 0, 1'b0));
    send_item(make_item(OpTick, 0, 0, 1'b0));
    send_item(make_item(OpTick, 0, 0, 1'b1));
    send_item(make_item(OpTick, 0, 0, 1'b0));
    drain_results();
    program_reg(RegThreshold, 512);
    program_reg(RegTimeout, 65535);
    program_reg(RegBlank, 0);
  endtask

  task automatic test_receiver_holdoff();
    idling_on       = 1'b0;
    rx_hold_pending = 1'b1;
    repeat (40) send_item(next_item());
    drain_results();
    idling_on = 1'b1;
  endtask

  task automatic test_sender_pause();
    repeat (20) send_item(next_item());
    drain_results();
    repeat (20) send_item(next_item());
    drain_results();
  endtask

  task automatic test_random_runs();
    homing_item_t it;
    int unsigned  counted;
    int unsigned  sends;
    bit           ignored;
    counted = 0;
    sends   = 0;
    random_config();
    while (counted < RandomItems) begin
      if (seq_phase == PhIdle && $urandom_range(0, 2) == 0) begin
        drain_results();
        random_config();
      end
      if (sends % 150 == 149) idling_on = ($urandom_range(0, 3) != 0);
      it      = next_item();
      ignored = (it.op == OpStart) ? (seq_phase != PhIdle) : (seq_phase == PhIdle);
      send_item(it);
      sends++;
      if (!ignored) counted++;
    end
    idling_on = 1'b1;
  endtask

  initial begin
    rst_ni = 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.op            <= OpTick;
    in_ch.stall_value   <= '0;
    in_ch.position      <= '0;
    in_ch.motor_running <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_stall_low_timeout_high();
    test_zero_timeout();
    test_receiver_holdoff();
    test_sender_pause();
    test_random_runs();

    drain_results();
    repeat (8) @(posedge clk_i);
    $display("sent %0d items, checked %0d results, %0d homing runs completed",
             sent_items, checked_results, homing_runs);
    $display("seek phases ended %0d times on stall, %0d on timeout; %0d register writes",
             stall_ends, timeout_ends, config_writes);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", fail_count,
               pending_results.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
